// File: src/sotl_pkg.sv
// Shared types, constants and table helpers for the stochastic oblique tree lookup.
// Depends on nothing; the level module and the top level import it.
package sotl_pkg;

  localparam int TREE_ROWS_DEF       = 8;
  localparam int SIGMOID_ENTRIES_DEF = 256;
  // Widest path of child choices: the tree has at most nine rows.
  localparam int PATH_MAX_W          = 8;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // Action codes of an input word.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // One word as it travels down the level pipeline.
  typedef struct packed {
    logic                     action;
    logic [7:0]               node;
    logic signed [23:0]       wx;
    logic signed [23:0]       wy;
    logic signed [23:0]       wb;
    logic [23:0]              colour;
    logic signed [15:0]       pos_x;
    logic signed [15:0]       pos_y;
    logic [63:0]              rnd;
    logic [PATH_MAX_W-1:0]    path;
  } item_t;

  // Power m of a Q30 value, each product rounded half up (elaboration only).
  function automatic longint unsigned pow_q(longint unsigned q, int m);
    longint unsigned acc;
    acc = Q30_ONE;
    for (int j = 0; j < m; j++) begin
      acc = (acc * q + (64'd1 << 29)) >> 30;
    end
    return acc;
  endfunction

endpackage

// File: src/sotl_level.sv
// One tree level: node plane store, plane evaluation, sigmoid lookup and decision.
// Depends on sotl_pkg; four register stages per level.
module sotl_level #(
  parameter int LEVEL           = 0,
  parameter int TREE_ROWS       = sotl_pkg::TREE_ROWS_DEF,
  parameter int SIGMOID_ENTRIES = sotl_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            draw_mode,
  input  logic            in_valid,
  input  sotl_pkg::item_t in_item,
  output logic            out_valid,
  output sotl_pkg::item_t out_item
);
  import sotl_pkg::*;

  localparam int DEPTH = 1 << LEVEL;
  localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
  localparam int BASE  = DEPTH - 1;
  localparam int LOGE  = $clog2(SIGMOID_ENTRIES);
  localparam int SHIFT = 30 - LOGE;

  // Taylor sum of exp(-8/E) in Q30 through the tenth-power term, truncating each term.
  localparam longint unsigned T1  = Q30_ONE * 8 / (SIGMOID_ENTRIES * 1);
  localparam longint unsigned T2  = T1 * 8 / (SIGMOID_ENTRIES * 2);
  localparam longint unsigned T3  = T2 * 8 / (SIGMOID_ENTRIES * 3);
  localparam longint unsigned T4  = T3 * 8 / (SIGMOID_ENTRIES * 4);
  localparam longint unsigned T5  = T4 * 8 / (SIGMOID_ENTRIES * 5);
  localparam longint unsigned T6  = T5 * 8 / (SIGMOID_ENTRIES * 6);
  localparam longint unsigned T7  = T6 * 8 / (SIGMOID_ENTRIES * 7);
  localparam longint unsigned T8  = T7 * 8 / (SIGMOID_ENTRIES * 8);
  localparam longint unsigned T9  = T8 * 8 / (SIGMOID_ENTRIES * 9);
  localparam longint unsigned T10 = T9 * 8 / (SIGMOID_ENTRIES * 10);
  localparam longint unsigned QE  = Q30_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;

  // Constant sigmoid table; the bin count is taken to be a power of two.
  logic [7:0] sig_rom [SIGMOID_ENTRIES];
  for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_rom
    localparam int OFF = 2 * gi + 1 - SIGMOID_ENTRIES;
    localparam longint unsigned EV  = pow_q(QE, (OFF < 0) ? -OFF : OFF);
    localparam longint unsigned DEN = Q30_ONE + EV;
    localparam longint unsigned NUM = (OFF >= 0) ? (64'd512 << 30) : 64'd512 * EV;
    localparam longint unsigned PV  = (NUM + DEN) / (2 * DEN);
    assign sig_rom[gi] = (PV > 64'd255) ? 8'd255 : PV[7:0];
  end

  // Plane store of this level: weight x, weight y and bias in one word.
  logic [71:0] mem [DEPTH];
  logic [71:0] rd;
  logic [9:0]  wr_rel;
  logic        wr_hit;

  assign wr_rel = 10'(in_item.node) - 10'(BASE);
  assign wr_hit = in_valid && (in_item.action == ACT_WRITE) &&
                  (10'(in_item.node) >= 10'(BASE)) && (10'(in_item.node) < 10'(2 * DEPTH - 1));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_rel[AW-1:0]] <= {in_item.wx, in_item.wy, in_item.wb};
    end
    rd <= mem[in_item.path[AW-1:0]];
  end

  // Stage registers.
  logic                v1, v2, v3;
  item_t               it1, it2, it3;
  logic signed [39:0]  px2, py2;
  logic signed [37:0]  pb2;
  logic [LOGE-1:0]     idx3;

  logic signed [23:0]  rwx, rwy, rwb;
  logic signed [42:0]  zsum, zsh;
  logic [LOGE-1:0]     idx_next;
  logic [7:0]          prob, draw;
  logic                first;
  item_t               out_item_next;

  assign rwx = rd[71:48];
  assign rwy = rd[47:24];
  assign rwb = rd[23:0];

  // Plane sum with the table offset of eight, in 26 fractional bits.
  assign zsum = 43'(px2) + 43'(py2) + 43'(pb2) + (43'sd8 <<< 26);
  assign zsh  = zsum >>> SHIFT;

  always_comb begin
    if (zsum < 0) begin
      idx_next = '0;
    end else if (zsh > 43'(SIGMOID_ENTRIES - 1)) begin
      idx_next = LOGE'(SIGMOID_ENTRIES - 1);
    end else begin
      idx_next = zsh[LOGE-1:0];
    end
  end

  // Decision against this level's random byte.
  assign prob  = sig_rom[idx3];
  assign draw  = it3.rnd[8*LEVEL +: 8];
  assign first = draw_mode ? ((11'd512 + 11'(draw)) < (11'(prob) * 11'd5))
                           : (draw < prob);

  // A query appends its child choice to the path; other words pass unchanged.
  always_comb begin
    out_item_next = it3;
    if (it3.action == ACT_QUERY) begin
      out_item_next.path = {it3.path[PATH_MAX_W-2:0], ~first};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    it1  <= in_item;
    it2  <= it1;
    px2  <= rwx * it1.pos_x;
    py2  <= rwy * it1.pos_y;
    pb2  <= 38'(rwb) <<< 14;
    it3  <= it2;
    idx3 <= idx_next;
    out_item <= out_item_next;
  end

endmodule

// File: src/stochastic_oblique_tree_lookup.sv
// Top level of the stochastic oblique tree lookup: level pipeline and leaf colour store.
// Depends on sotl_pkg and sotl_level.
//
// Usage: an input word is taken at each clock edge with start high and busy low; busy
// is always low, so a word may enter every cycle. action selects a node write
// (node_number with plane or colour fields) or a query (pos_x, pos_y, random_bits).
// Words run in order through TREE_ROWS-1 levels of four register stages each, then a
// leaf colour read register that drives the result ports. A query gives one result
// word, marked by done for one cycle; done is registered beside the leaf colour read,
// so done and the colour appear in the same cycle; one word per cycle sustained.
// Write words give no result and reach each store in order with the queries around
// them. cfg_write loads draw_mode from cfg_data; change it only while idle. Reset
// clears valid bits and draw_mode; the node stores are not cleared and must be
// written before they are read. The receiver cannot stall: each result must be
// taken in its cycle.
module stochastic_oblique_tree_lookup #(
  parameter int TREE_ROWS       = sotl_pkg::TREE_ROWS_DEF,
  parameter int SIGMOID_ENTRIES = sotl_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [7:0]         node_number,
  input  logic signed [23:0] weight_x,
  input  logic signed [23:0] weight_y,
  input  logic signed [23:0] plane_bias,
  input  logic [7:0]         red_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         blue_in,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [63:0]        random_bits,
  output logic               done,
  output logic [7:0]         red_out,
  output logic [7:0]         green_out,
  output logic [7:0]         blue_out,
  output logic [6:0]         leaf_reached
);
  import sotl_pkg::*;

  localparam int LEVELS = TREE_ROWS - 1;
  localparam int LEAVES = 1 << LEVELS;
  localparam int INNER  = LEAVES - 1;

  logic draw_mode;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode <= 1'b0;
    end else if (cfg_write) begin
      draw_mode <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // Word entering the pipeline.
  logic  lv [LEVELS+1];
  item_t li [LEVELS+1];

  always_comb begin
    lv[0]        = start;
    li[0].action = action;
    li[0].node   = node_number;
    li[0].wx     = weight_x;
    li[0].wy     = weight_y;
    li[0].wb     = plane_bias;
    li[0].colour = {red_in, green_in, blue_in};
    li[0].pos_x  = pos_x;
    li[0].pos_y  = pos_y;
    li[0].rnd    = random_bits;
    li[0].path   = '0;
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    sotl_level #(
      .LEVEL(k),
      .TREE_ROWS(TREE_ROWS),
      .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
    ) u_level (
      .clk(clk),
      .rst(rst),
      .draw_mode(draw_mode),
      .in_valid(lv[k]),
      .in_item(li[k]),
      .out_valid(lv[k+1]),
      .out_item(li[k+1])
    );
  end

  // Leaf colour store, written and read in word order.
  logic [23:0]       leaf_mem [LEAVES];
  logic [23:0]       leaf_rd;
  logic [9:0]        leaf_rel;
  logic              leaf_hit;
  logic              qv;
  logic [LEVELS-1:0] qpath;
  item_t             tail;

  assign tail     = li[LEVELS];
  assign leaf_rel = 10'(tail.node) - 10'(INNER);
  assign leaf_hit = lv[LEVELS] && (tail.action == ACT_WRITE) &&
                    (10'(tail.node) >= 10'(INNER)) && (10'(tail.node) < 10'(INNER + LEAVES));

  always_ff @(posedge clk) begin
    if (leaf_hit) begin
      leaf_mem[leaf_rel[LEVELS-1:0]] <= tail.colour;
    end
    leaf_rd <= leaf_mem[tail.path[LEVELS-1:0]];
    qpath   <= tail.path[LEVELS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else begin
      qv <= lv[LEVELS] && (tail.action == ACT_QUERY);
    end
  end

  // Result word.
  assign done         = qv;
  assign red_out      = leaf_rd[23:16];
  assign green_out    = leaf_rd[15:8];
  assign blue_out     = leaf_rd[7:0];
  assign leaf_reached = 7'(qpath);

endmodule
